// ----- design/rgb3_pkg.sv -----
// Shared types and constants of the RGB 3x3 convolution filter.
`timescale 1ns / 1ps
`default_nettype none
package rgb3_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIXEL_MAX   = 255;
    localparam int SUM_W       = 20;
    localparam int QUO_W       = 19;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int GEOM_W      = 11;
    localparam int POS_W       = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_DIVISOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef t_pixel [KERNEL_SIZE-1:0] t_column;
    typedef logic signed [7:0] t_coef;
    typedef t_coef [KERNEL_SIZE-1:0] t_coef_col;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef t_sum [2:0] t_plane_sums;

    typedef struct packed {
        logic       first_of_frame;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_of_frame;
    } t_out_item;

endpackage
`default_nettype wire

// ----- design/rgb_3x3_convolution_filter_unit.sv -----
// Top level of the RGB 3x3 convolution filter: line store, window cells and dividers.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Handshake               Payload
//  input     in         i_in_valid/o_in_stall   i_in_data  (rgb3_pkg::t_in_item)
//  output    out        o_out_valid/i_out_stall o_out_data (rgb3_pkg::t_out_item)
//  config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
//  A pixel is taken only while the control sequencer is idle. A border pixel
//  needs a line store read, then write and window shift; an interior pixel
//  then starts the dividers (one quotient bit per cycle) and waits for them
//  and a free output register. Reset is synchronous and active low; it
//  clears position, sequencer and output valid, while the line store is left
//  undefined until written. A stalled result stays in the output register and
//  the next pixel may still be transferred; the divider result then waits.
//
module rgb_3x3_convolution_filter_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire rgb3_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output rgb3_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [rgb3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rgb3_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > rgb3_pkg::GEOM_W) ? WW + 1 : rgb3_pkg::GEOM_W + 1;
    localparam int KS   = rgb3_pkg::KERNEL_SIZE;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;

    // Configuration registers.
    logic [rgb3_pkg::CFG_W-1:0]  r_k_top, r_k_mid, r_k_bot;
    logic signed [7:0]           r_div;
    logic [rgb3_pkg::GEOM_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top  <= '0;
            r_k_mid  <= rgb3_pkg::CFG_W'(256);
            r_k_bot  <= '0;
            r_div    <= 8'sd1;
            r_width  <= rgb3_pkg::GEOM_W'(1024);
            r_height <= rgb3_pkg::GEOM_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rgb3_pkg::CFG_KERNEL_TOP:    r_k_top  <= i_cfg_data;
                rgb3_pkg::CFG_KERNEL_MIDDLE: r_k_mid  <= i_cfg_data;
                rgb3_pkg::CFG_KERNEL_BOTTOM: r_k_bot  <= i_cfg_data;
                rgb3_pkg::CFG_SUM_DIVISOR:   r_div    <= i_cfg_data[7:0];
                rgb3_pkg::CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data[rgb3_pkg::GEOM_W-1:0];
                rgb3_pkg::CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data[rgb3_pkg::GEOM_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective geometry, saturated to the supported range.
    logic [CMPW-1:0] w_eff, h_eff;

    always_comb begin
        if (CMPW'(r_width) < CMPW'(3)) begin
            w_eff = CMPW'(3);
        end else if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_width);
        end
        if (CMPW'(r_height) < CMPW'(3)) begin
            h_eff = CMPW'(3);
        end else if (CMPW'(r_height) > CMPW'(rgb3_pkg::MAX_HEIGHT)) begin
            h_eff = CMPW'(rgb3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = CMPW'(r_height);
        end
    end

    // Sequencer and transfer detection.
    logic [2:0] r_state, n_state;
    logic       in_xfer, out_xfer;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = o_out_valid && !i_out_stall;

    // Position of the current pixel, with a frame start and clamping applied.
    logic [CW-1:0]            r_col_pos;
    logic [rgb3_pkg::POS_W-1:0] r_row_pos;
    logic [CMPW-1:0]          c_raw, r_raw, c_cur, r_cur;

    always_comb begin
        c_raw = i_in_data.first_of_frame ? '0 : CMPW'(r_col_pos);
        r_raw = i_in_data.first_of_frame ? '0 : CMPW'(r_row_pos);
        c_cur = (c_raw >= w_eff) ? w_eff - 1'b1 : c_raw;
        r_cur = (r_raw >= h_eff) ? h_eff - 1'b1 : r_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (in_xfer) begin
            if (c_cur + 1'b1 >= w_eff) begin
                r_col_pos <= '0;
                r_row_pos <= (r_cur + 1'b1 >= h_eff) ? '0 : rgb3_pkg::POS_W'(r_cur + 1'b1);
            end else begin
                r_col_pos <= CW'(c_cur + 1'b1);
                r_row_pos <= rgb3_pkg::POS_W'(r_cur);
            end
        end
    end

    // Item registers for the pixel being worked on.
    rgb3_pkg::t_pixel          r_pix;
    logic [CW-1:0]             r_col;
    logic [rgb3_pkg::POS_W-1:0] r_out_row, r_out_col;
    logic                      r_interior, r_last;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pix      <= '{blue: i_in_data.in_blue, green: i_in_data.in_green,
                            red: i_in_data.in_red};
            r_col      <= CW'(c_cur);
            r_out_row  <= rgb3_pkg::POS_W'(r_cur - 1'b1);
            r_out_col  <= rgb3_pkg::POS_W'(c_cur - 1'b1);
            r_interior <= (r_cur >= CMPW'(2)) && (c_cur >= CMPW'(2));
            r_last     <= (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
        end
    end

    // Line store: each entry holds the pixels two rows up (low half) and one row up.
    logic [2*24-1:0] line_mem [MAX_WIDTH];
    logic [2*24-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rd <= line_mem[CW'(c_cur)];
        end
        if (r_state == S_SHIFT) begin
            line_mem[r_col] <= {r_pix, r_rd[47:24]};
        end
    end

    // Window: a chain of three column cells; new columns enter on the right.
    rgb3_pkg::t_column     col_in  [KS];
    rgb3_pkg::t_column     col_out [KS];
    rgb3_pkg::t_coef_col   cell_coef [KS];
    rgb3_pkg::t_plane_sums cell_sum [KS];
    logic                  shift_en;

    assign shift_en = (r_state == S_SHIFT);

    for (genvar j = 0; j < KS; j++) begin : g_cell
        assign cell_coef[j][0] = r_k_top[8*j +: 8];
        assign cell_coef[j][1] = r_k_mid[8*j +: 8];
        assign cell_coef[j][2] = r_k_bot[8*j +: 8];
        if (j == KS - 1) begin : g_entry
            assign col_in[j][0] = r_rd[23:0];
            assign col_in[j][1] = r_rd[47:24];
            assign col_in[j][2] = r_pix;
        end else begin : g_link
            assign col_in[j] = col_out[j+1];
        end
        rgb3_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (shift_en),
            .i_col   (col_in[j]),
            .i_coef  (cell_coef[j]),
            .o_col   (col_out[j]),
            .o_sum   (cell_sum[j])
        );
    end

    // Plane sums over the three cells, and one divider per plane.
    rgb3_pkg::t_plane_sums plane_sum;
    logic signed [7:0]     div_eff;
    logic [2:0]            div_done;
    logic [7:0]            div_res [3];

    assign div_eff = (r_div == 8'sd0) ? 8'sd1 : r_div;

    for (genvar p = 0; p < 3; p++) begin : g_plane
        assign plane_sum[p] = cell_sum[0][p] + cell_sum[1][p] + cell_sum[2][p];
        rgb3_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_state == S_MAC),
            .i_dividend (plane_sum[p]),
            .i_divisor  (div_eff),
            .o_done     (div_done[p]),
            .o_result   (div_res[p])
        );
    end

    // The result loads when the dividers finish and the output register is free.
    logic out_load;

    assign out_load = (r_state == S_DIV) && (&div_done) && (!o_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_xfer) n_state = S_SHIFT;
            S_SHIFT: n_state = r_interior ? S_MAC : S_IDLE;
            S_MAC:   n_state = S_DIV;
            S_DIV:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register.
    logic                r_out_valid;
    rgb3_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_row       <= r_out_row;
            r_out.out_col       <= r_out_col;
            r_out.out_red       <= div_res[0];
            r_out.out_green     <= div_res[1];
            r_out.out_blue      <= div_res[2];
            r_out.last_of_frame <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ----- design/rgb3_cell.sv -----
// One window column cell: holds three pixels and forms its column's weighted sums.
`timescale 1ns / 1ps
`default_nettype none
module rgb3_cell (
    input  wire logic                i_clk,
    input  wire logic                i_shift,
    input  wire rgb3_pkg::t_column   i_col,
    input  wire rgb3_pkg::t_coef_col i_coef,
    output rgb3_pkg::t_column        o_col,
    output rgb3_pkg::t_plane_sums    o_sum
);

    rgb3_pkg::t_column r_col;

    // The column moves one cell to the left on every shift.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    always_comb begin
        logic signed [16:0] v_prod;
        logic [7:0]         v_px;
        o_sum = '0;
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < rgb3_pkg::KERNEL_SIZE; k++) begin
                v_px = (p == 0) ? r_col[k].red : ((p == 1) ? r_col[k].green : r_col[k].blue);
                v_prod = $signed({1'b0, v_px}) * i_coef[k];
                o_sum[p] = o_sum[p] + rgb3_pkg::t_sum'(v_prod);
            end
        end
    end

    assign o_col = r_col;

endmodule
`default_nettype wire

// ----- design/rgb3_div.sv -----
// Bit-serial signed divider with truncation toward zero and clamp to 0..255.
`timescale 1ns / 1ps
`default_nettype none
module rgb3_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire rgb3_pkg::t_sum           i_dividend,
    input  wire logic signed [7:0]        i_divisor,
    output logic                          o_done,
    output logic [7:0]                    o_result
);

    localparam int CNT_W = $clog2(rgb3_pkg::QUO_W + 1);

    logic [rgb3_pkg::QUO_W-1:0] r_quo;
    logic [7:0]                 r_rem;
    logic [7:0]                 r_dmag;
    logic                       r_neg;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_done;

    logic [rgb3_pkg::SUM_W-1:0] a_mag;
    logic [7:0]                 d_mag;
    logic [8:0]                 trial;
    logic [7:0]                 shifted;

    assign a_mag   = i_dividend[rgb3_pkg::SUM_W-1] ? -i_dividend : i_dividend;
    assign d_mag   = i_divisor[7] ? 8'(-i_divisor) : 8'(i_divisor);
    assign shifted = {r_rem[6:0], r_quo[rgb3_pkg::QUO_W-1]};
    assign trial   = {1'b0, shifted} - {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(rgb3_pkg::QUO_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
        end
    end

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= a_mag[rgb3_pkg::QUO_W-1:0];
            r_rem  <= '0;
            r_dmag <= d_mag;
            r_neg  <= i_dividend[rgb3_pkg::SUM_W-1] ^ i_divisor[7];
        end else if (r_cnt != '0) begin
            if (!trial[8]) begin
                r_rem <= trial[7:0];
                r_quo <= {r_quo[rgb3_pkg::QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[rgb3_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_neg && (r_quo != '0)) begin
            o_result = '0;
        end else if (r_quo > rgb3_pkg::QUO_W'(rgb3_pkg::PIXEL_MAX)) begin
            o_result = 8'(rgb3_pkg::PIXEL_MAX);
        end else begin
            o_result = r_quo[7:0];
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire
